/* rtl/rgbhsl_pkg.sv */
`timescale 1ns / 1ps

package rgbhsl_pkg;

    // divider geometry: numerator, divisor and quotient widths
    localparam int NUM_W = 18;
    localparam int DEN_W = 10;
    localparam int QUO_W = 9;
    localparam int LANES = 2;

    // lane assignment inside the divider
    localparam int LANE_HUE   = 0;
    localparam int LANE_SAT   = 1;

    // lightness: floor(N / 510) as (N * 32897) >> 24, exact for N up to 51255
    localparam logic [15:0] LIGHT_RCP   = 16'd32897;
    localparam int          LIGHT_SHIFT = 24;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_lane;

endpackage

/* rtl/rgbhsl_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, several lanes
// side by side. The quotient must be below 2**QUO_W, so the top numerator
// bits already sit below the divisor and seed the partial remainder.
module rgbhsl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rgbhsl_pkg::t_div_lane       i_lanes [rgbhsl_pkg::LANES],
    output logic                        o_valid,
    output logic [rgbhsl_pkg::QUO_W-1:0] o_quo  [rgbhsl_pkg::LANES]
);
    import rgbhsl_pkg::*;

    logic [DEN_W-1:0] r_rem [QUO_W][LANES];
    logic [QUO_W-1:0] r_low [QUO_W][LANES];
    logic [QUO_W-1:0] r_quo [QUO_W][LANES];
    logic [DEN_W-1:0] r_den [QUO_W][LANES];
    logic             r_vld [QUO_W];

    logic [DEN_W-1:0] n_rem [QUO_W][LANES];
    logic [QUO_W-1:0] n_low [QUO_W][LANES];
    logic [QUO_W-1:0] n_quo [QUO_W][LANES];
    logic [DEN_W-1:0] n_den [QUO_W][LANES];

    // one compare-subtract step per stage
    always_comb begin
        logic [DEN_W-1:0] s_rem;
        logic [QUO_W-1:0] s_low;
        logic [QUO_W-1:0] s_quo;
        logic [DEN_W-1:0] s_den;
        logic [DEN_W:0]   t;
        for (int s = 0; s < QUO_W; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    s_rem = DEN_W'(i_lanes[l].num[NUM_W-1:QUO_W]);
                    s_low = i_lanes[l].num[QUO_W-1:0];
                    s_quo = '0;
                    s_den = i_lanes[l].den;
                end else begin
                    s_rem = r_rem[s-1][l];
                    s_low = r_low[s-1][l];
                    s_quo = r_quo[s-1][l];
                    s_den = r_den[s-1][l];
                end
                t = {s_rem, s_low[QUO_W-1]};
                if (t >= {1'b0, s_den}) begin
                    n_rem[s][l] = DEN_W'(t - {1'b0, s_den});
                    n_quo[s][l] = {s_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = t[DEN_W-1:0];
                    n_quo[s][l] = {s_quo[QUO_W-2:0], 1'b0};
                end
                n_low[s][l] = {s_low[QUO_W-2:0], 1'b0};
                n_den[s][l] = s_den;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_quo <= n_quo;
            r_den <= n_den;
        end
    end

    // valid bits ride along
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QUO_W; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < QUO_W; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) o_quo[l] = r_quo[QUO_W-1][l];
    end

endmodule

/* rtl/rgb_to_hsl_converter.sv */
`timescale 1ns / 1ps

// RGB to HSL converter.
// Input channel: i_valid with i_red, i_green, i_blue (8 bits each); a beat
// is taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid with o_hue_deg (0..360 degrees), o_sat_pct and
// o_light_pct (0..100 percent), all rounded half up; a beat leaves on an
// edge with o_valid high and i_stall low.
// Stages in order: an input register, a max/min stage, a numerator
// stage and nine stages of the restoring divider, whose last stage is the
// output register. One pixel enters every clock while o_stall is low.
// Throughput: one beat per cycle as long as the receiver does not stall.
// When the receiver stalls while a result is shown, the whole pipeline
// freezes and o_stall rises in the same cycle; nothing is lost or repeated.
// Greys give hue and saturation zero; hue may round up to 360.
// Reset (synchronous, active low) clears all valid bits; no results show
// until new beats arrive.
module rgb_to_hsl_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [8:0] o_hue_deg,
    output logic [6:0] o_sat_pct,
    output logic [6:0] o_light_pct
);
    import rgbhsl_pkg::*;

    logic en;

    // stage A: input capture
    logic       r_a_vld;
    logic [7:0] r_a_r, r_a_g, r_a_b;

    // stage B: extremes
    logic       r_b_vld;
    logic [7:0] r_b_r, r_b_g, r_b_b, r_b_d;
    logic [8:0] r_b_sum;
    logic       r_b_red_max, r_b_grn_max;

    // stage C: divider operands
    logic      r_c_vld;
    t_div_lane r_c_lanes [LANES];
    t_div_lane n_c_lanes [LANES];
    logic [15:0] r_c_lnum, n_c_lnum;

    // lightness travels beside the divider
    logic [31:0] light_prod;
    logic [6:0]  r_l [QUO_W];

    logic [7:0] n_mx, n_mn;
    logic [QUO_W-1:0] quo [LANES];

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    // max/min with red winning ties, then green
    always_comb begin
        n_mx = r_a_r;
        n_mn = r_a_r;
        if (r_a_g > n_mx) n_mx = r_a_g;
        if (r_a_b > n_mx) n_mx = r_a_b;
        if (r_a_g < n_mn) n_mn = r_a_g;
        if (r_a_b < n_mn) n_mn = r_a_b;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_r       <= i_red;
            r_a_g       <= i_green;
            r_a_b       <= i_blue;
            r_b_r       <= r_a_r;
            r_b_g       <= r_a_g;
            r_b_b       <= r_a_b;
            r_b_d       <= n_mx - n_mn;
            r_b_sum     <= {1'b0, n_mx} + {1'b0, n_mn};
            r_b_red_max <= (n_mx == r_a_r);
            r_b_grn_max <= (n_mx == r_a_g);
            r_c_lanes   <= n_c_lanes;
            r_c_lnum    <= n_c_lnum;
        end
    end

    // numerators and divisors, each rounded as (2N + D) / (2D)
    always_comb begin
        logic [NUM_W-1:0] d_x, r_x, g_x, b_x, hnum;
        logic [8:0]       den;
        d_x = NUM_W'(r_b_d);
        r_x = NUM_W'(r_b_r);
        g_x = NUM_W'(r_b_g);
        b_x = NUM_W'(r_b_b);
        if (r_b_red_max) begin
            if (r_b_g >= r_b_b) hnum = NUM_W'(60) * (g_x - b_x);
            else hnum = NUM_W'(360) * d_x - NUM_W'(60) * (b_x - g_x);
        end else if (r_b_grn_max) begin
            hnum = NUM_W'(120) * d_x + NUM_W'(60) * b_x - NUM_W'(60) * r_x;
        end else begin
            hnum = NUM_W'(240) * d_x + NUM_W'(60) * r_x - NUM_W'(60) * g_x;
        end
        den = (r_b_sum > 9'd255) ? (9'd510 - r_b_sum) : r_b_sum;
        if (r_b_d == 8'd0) begin
            n_c_lanes[LANE_HUE].num = '0;
            n_c_lanes[LANE_HUE].den = DEN_W'(1);
            n_c_lanes[LANE_SAT].num = '0;
            n_c_lanes[LANE_SAT].den = DEN_W'(1);
        end else begin
            n_c_lanes[LANE_HUE].num = {hnum[NUM_W-2:0], 1'b0} + d_x;
            n_c_lanes[LANE_HUE].den = {1'b0, r_b_d, 1'b0};
            n_c_lanes[LANE_SAT].num = NUM_W'(200) * d_x + NUM_W'(den);
            n_c_lanes[LANE_SAT].den = {den, 1'b0};
        end
        // lightness numerator: 100 * sum + 255, later divided by 510
        n_c_lnum = {7'b0, r_b_sum} * 16'd100 + 16'd255;
    end

    // lightness quotient by reciprocal, then delayed to match the divider
    assign light_prod = {16'b0, r_c_lnum} * {16'b0, LIGHT_RCP};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l[0] <= light_prod[LIGHT_SHIFT +: 7];
            for (int s = 1; s < QUO_W; s++) r_l[s] <= r_l[s-1];
        end
    end

    rgbhsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_lanes (r_c_lanes),
        .o_valid (o_valid),
        .o_quo   (quo)
    );

    assign o_hue_deg   = quo[LANE_HUE];
    assign o_sat_pct   = quo[LANE_SAT][6:0];
    assign o_light_pct = r_l[QUO_W-1];

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_red;
    logic [7:0] i_green;
    logic [7:0] i_blue;
    logic       o_valid;
    logic       i_stall;
    logic [8:0] o_hue_deg;
    logic [6:0] o_sat_pct;
    logic [6:0] o_light_pct;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_pixel;

    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] light;
    } t_hsl;

    t_pixel pixel_q[$];
    t_hsl   hsl_q[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     errors;
    int     cycles;
    bit     hold_off;

    rgb_to_hsl_converter dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // half-up rounded quotient
    function automatic int unsigned rnd_div(int unsigned num, int unsigned den);
        if (den == 0) return 0;
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic t_hsl hsl_of(t_pixel p);
        int unsigned r, g, b, mx, mn, sum, d, den, hnum;
        t_hsl h;
        r = p.r;
        g = p.g;
        b = p.b;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        d = mx - mn;
        h.light = 7'(rnd_div(100 * sum, 510));
        h.hue = '0;
        h.sat = '0;
        if (d != 0) begin
            den = (sum > 255) ? (510 - sum) : sum;
            h.sat = 7'(rnd_div(100 * d, den));
            if (mx == r) begin
                // red sector wraps when green is below blue
                hnum = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
            end else if (mx == g) begin
                hnum = 120 * d + 60 * b - 60 * r;
            end else begin
                hnum = 240 * d + 60 * r - 60 * g;
            end
            h.hue = 9'(rnd_div(hnum, d));
        end
        return h;
    endfunction

    // driver: one beat per acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                hsl_q.push_back(hsl_of({i_red, i_green, i_blue}));
                pixel_q.pop_front();
            end
            if ((i_valid && o_stall) ||
                (pixel_q.size() > 0 && !hold_off &&
                 $urandom_range(99) >= send_idle_pct)) begin
                if (!(i_valid && o_stall)) begin
                    i_valid <= (pixel_q.size() > 0) ? 1'b1 : 1'b0;
                    {i_red, i_green, i_blue} <= pixel_q[0];
                end
            end else begin
                i_valid <= 1'b0;
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: compare against the oldest expected result
    always @(posedge i_clk) begin
        t_hsl want;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (hsl_q.size() == 0) begin
                $display("%0t unexpected beat: hue %0d sat %0d light %0d", $time,
                         o_hue_deg, o_sat_pct, o_light_pct);
                errors = errors + 1;
            end else begin
                want = hsl_q.pop_front();
                if (want.hue !== o_hue_deg) begin
                    $display("%0t hue: expected %0d actual %0d", $time, want.hue, o_hue_deg);
                    errors = errors + 1;
                end
                if (want.sat !== o_sat_pct) begin
                    $display("%0t sat: expected %0d actual %0d", $time, want.sat, o_sat_pct);
                    errors = errors + 1;
                end
                if (want.light !== o_light_pct) begin
                    $display("%0t light: expected %0d actual %0d", $time, want.light,
                             o_light_pct);
                    errors = errors + 1;
                end
            end
        end
        if (cycles > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p = 24'($urandom);
        case ($urandom_range(5))
            0: p.g = p.r;
            1: p.b = p.g;
            2: begin p.g = p.r; p.b = p.r; end
            default: ;
        endcase
        return p;
    endfunction

    task automatic drain();
        wait (pixel_q.size() == 0 && hsl_q.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        t_pixel p;
        errors = 0;
        cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, greys, sector ties, red wrap, near full turn
        pixel_q.push_back({8'd0, 8'd0, 8'd0});
        pixel_q.push_back({8'd255, 8'd255, 8'd255});
        pixel_q.push_back({8'd128, 8'd128, 8'd128});
        pixel_q.push_back({8'd255, 8'd0, 8'd0});
        pixel_q.push_back({8'd0, 8'd255, 8'd0});
        pixel_q.push_back({8'd0, 8'd0, 8'd255});
        pixel_q.push_back({8'd255, 8'd255, 8'd0});
        pixel_q.push_back({8'd0, 8'd255, 8'd255});
        pixel_q.push_back({8'd255, 8'd0, 8'd255});
        pixel_q.push_back({8'd255, 8'd0, 8'd1});
        pixel_q.push_back({8'd255, 8'd0, 8'd2});
        pixel_q.push_back({8'd255, 8'd254, 8'd255});
        pixel_q.push_back({8'd1, 8'd0, 8'd0});
        pixel_q.push_back({8'd0, 8'd1, 8'd1});
        pixel_q.push_back({8'd200, 8'd50, 8'd100});
        pixel_q.push_back({8'd10, 8'd200, 8'd200});
        pixel_q.push_back({8'd127, 8'd128, 8'd0});
        pixel_q.push_back({8'd170, 8'd85, 8'd255});
        drain();

        // random phases with varying idle and stall rates
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 31 : 75) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 31 : 75) : 0;
            for (int n = 0; n < 310; n++) pixel_q.push_back(rand_pixel());
            if (ph == 0) begin
                // sender pauses until everything has come out
                wait (pixel_q.size() < 150);
                hold_off = 1'b1;
                wait (hsl_q.size() == 0);
                hold_off = 1'b0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
